/* hw/rtl/assert_macros.svh */
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define FPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define FPA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs through reset.
`define FPA_ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/fpa_pkg.sv */
// Shared constants, types and helpers for the frame pixel accumulator.
`timescale 1ns / 1ps

package fpa_pkg;

  localparam int MAX_PIXELS   = 16384;
  localparam int GROUP_PIXELS = 8;
  localparam int PIX_W        = $clog2(MAX_PIXELS);
  localparam int CNT_W        = PIX_W + 1;
  localparam int GRP_W        = $clog2(GROUP_PIXELS);
  localparam int ACC_DEPTH    = 3 * MAX_PIXELS;
  localparam int ACC_AW       = $clog2(ACC_DEPTH);
  localparam int ACC_W        = 16;
  localparam int BYTE_W       = 8;
  localparam int PROD_W       = 2 * BYTE_W;
  localparam int IDX_W        = 16;
  localparam int MODE_W       = 2;
  localparam int SHIFT_W      = 4;
  localparam int CFG_W        = 15;
  localparam int CFG_IDX_W    = 3;
  localparam int IN_DATA_W    = 3 * BYTE_W + IDX_W;
  localparam int OUT_DEPTH    = 3;
  localparam int OUT_CNT_W    = $clog2(OUT_DEPTH + 1);
  localparam int OUT_PTR_W    = $clog2(OUT_DEPTH);
  localparam int STEP_W       = $clog2(PIX_W + 1);

  // tdata field offsets
  localparam int RED_LSB   = 0;
  localparam int GREEN_LSB = BYTE_W;
  localparam int BLUE_LSB  = 2 * BYTE_W;
  localparam int IDX_LSB   = 3 * BYTE_W;

  localparam logic [MODE_W-1:0] MODE_GREY        = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INTERLEAVED = 2'd1;
  localparam int                MODE_PLANAR_BIT  = 1;

  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [1:0] SUB_LAST = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE,
    REG_WEIGHT_RED,
    REG_WEIGHT_GREEN,
    REG_WEIGHT_BLUE,
    REG_WEIGHT_SHIFT,
    REG_PIXEL_COUNT,
    REG_BLOCK_PIXELS
  } reg_idx_t;

  typedef enum logic {
    OP_ADD,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    logic              valid;
    op_kind_t          kind;
    logic              oor;
    logic [ACC_AW-1:0] addr;
    logic [ACC_W-1:0]  value;
  } acc_op_t;

  typedef struct packed {
    logic clr_busy;
    logic rd_inflight;
  } mem_status_t;

  function automatic logic [CNT_W-1:0] clamp_pixels(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > CFG_W'(MAX_PIXELS)) begin
      r = CNT_W'(MAX_PIXELS);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/fpa_rem_unit.sv */
// Bit-serial remainder unit: pixel position modulo block size.
`timescale 1ns / 1ps

module fpa_rem_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [fpa_pkg::PIX_W-1:0] dividend,
  input  logic [fpa_pkg::CNT_W-1:0] divisor,
  output logic                     busy,
  output logic                     done,
  output logic [fpa_pkg::PIX_W-1:0] rem
);

  logic                       busy_r;
  logic [fpa_pkg::STEP_W-1:0] cnt_r;
  logic [fpa_pkg::PIX_W-1:0]  dvd_r;
  logic [fpa_pkg::PIX_W-1:0]  rem_r;
  logic [fpa_pkg::CNT_W-1:0]  trial;
  logic [fpa_pkg::CNT_W-1:0]  rem_step;

  // one quotient bit per cycle, restoring
  assign trial    = {rem_r, dvd_r[fpa_pkg::PIX_W-1]};
  assign rem_step = (trial >= divisor) ? (trial - divisor) : trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= fpa_pkg::STEP_W'(fpa_pkg::PIX_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == fpa_pkg::STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_step[fpa_pkg::PIX_W-1:0];
    end
  end

  assign busy = busy_r;
  assign done = busy_r && (cnt_r == fpa_pkg::STEP_W'(1)) && !start;
  assign rem  = rem_step[fpa_pkg::PIX_W-1:0];

endmodule

/* hw/rtl/fpa_front.sv */
// Config registers, pixel geometry tracking and accumulator op sequencing.
`timescale 1ns / 1ps

module fpa_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fpa_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [fpa_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                             in_tuser,
  input  fpa_pkg::mem_status_t             mem_st,
  input  logic [fpa_pkg::OUT_CNT_W-1:0]    out_level,
  output fpa_pkg::acc_op_t                 op
);

  // configuration
  logic [fpa_pkg::MODE_W-1:0]  mode_r;
  logic [fpa_pkg::BYTE_W-1:0]  wr_r, wg_r, wb_r;
  logic [fpa_pkg::SHIFT_W-1:0] shift_r;
  logic [fpa_pkg::CFG_W-1:0]   pcount_r, bpix_r;
  logic                        geo_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= fpa_pkg::MODE_GREY;
      wr_r        <= '0;
      wg_r        <= '0;
      wb_r        <= '0;
      shift_r     <= fpa_pkg::SHIFT_W'(8);
      pcount_r    <= fpa_pkg::CFG_W'(fpa_pkg::MAX_PIXELS);
      bpix_r      <= fpa_pkg::CFG_W'(fpa_pkg::MAX_PIXELS);
      geo_start_r <= 1'b0;
    end else begin
      geo_start_r <= cfg_we && ((cfg_index == fpa_pkg::REG_PIXEL_COUNT) ||
                                (cfg_index == fpa_pkg::REG_BLOCK_PIXELS));
      if (cfg_we) begin
        unique case (cfg_index)
          fpa_pkg::REG_MODE:         mode_r   <= cfg_wdata[fpa_pkg::MODE_W-1:0];
          fpa_pkg::REG_WEIGHT_RED:   wr_r     <= cfg_wdata[fpa_pkg::BYTE_W-1:0];
          fpa_pkg::REG_WEIGHT_GREEN: wg_r     <= cfg_wdata[fpa_pkg::BYTE_W-1:0];
          fpa_pkg::REG_WEIGHT_BLUE:  wb_r     <= cfg_wdata[fpa_pkg::BYTE_W-1:0];
          fpa_pkg::REG_WEIGHT_SHIFT: shift_r  <= cfg_wdata[fpa_pkg::SHIFT_W-1:0];
          fpa_pkg::REG_PIXEL_COUNT:  pcount_r <= cfg_wdata;
          fpa_pkg::REG_BLOCK_PIXELS: bpix_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  logic [fpa_pkg::CNT_W-1:0] frame, bsize;
  assign frame = fpa_pkg::clamp_pixels(pcount_r);
  assign bsize = fpa_pkg::clamp_pixels(bpix_r);

  // geometry: stored position may sit past a shrunk frame; use 0 then
  logic [fpa_pkg::PIX_W-1:0] pos_r, pib_r, base_r;
  logic [fpa_pkg::PIX_W-1:0] eff_pos;
  assign eff_pos = ({1'b0, pos_r} >= frame) ? '0 : pos_r;

  logic                      rem_busy, rem_done;
  logic [fpa_pkg::PIX_W-1:0] rem_val;

  fpa_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (geo_start_r),
    .dividend (eff_pos),
    .divisor  (bsize),
    .busy     (rem_busy),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // input field decode
  logic [fpa_pkg::BYTE_W-1:0] in_red, in_green, in_blue;
  logic [fpa_pkg::IDX_W-1:0]  in_idx;
  assign in_red   = in_tdata[fpa_pkg::RED_LSB   +: fpa_pkg::BYTE_W];
  assign in_green = in_tdata[fpa_pkg::GREEN_LSB +: fpa_pkg::BYTE_W];
  assign in_blue  = in_tdata[fpa_pkg::BLUE_LSB  +: fpa_pkg::BYTE_W];
  assign in_idx   = in_tdata[fpa_pkg::IDX_LSB   +: fpa_pkg::IDX_W];

  // planar block: full groups of eight run up to the clipped block length
  logic [fpa_pkg::CNT_W-1:0] blk_len_raw, blk_len, full_len;
  logic                      planar, grouped;
  logic [fpa_pkg::GRP_W-1:0] grp_j;
  logic [fpa_pkg::PIX_W-1:0] grp_start;

  assign planar      = mode_r[fpa_pkg::MODE_PLANAR_BIT];
  assign blk_len_raw = frame - {1'b0, base_r};
  assign blk_len     = (blk_len_raw > bsize) ? bsize : blk_len_raw;
  assign full_len    = {blk_len[fpa_pkg::CNT_W-1:fpa_pkg::GRP_W], {fpa_pkg::GRP_W{1'b0}}};
  assign grouped     = planar && ({1'b0, pib_r} < full_len);
  assign grp_j       = pib_r[fpa_pkg::GRP_W-1:0];
  assign grp_start   = eff_pos - fpa_pkg::PIX_W'(grp_j);

  // next geometry after one pixel
  logic [fpa_pkg::CNT_W-1:0] pos_inc, pib_inc;
  logic                      wrap;
  logic [fpa_pkg::PIX_W-1:0] pos_nxt;
  assign pos_inc = {1'b0, eff_pos} + 1'b1;
  assign wrap    = (pos_inc >= frame);
  assign pos_nxt = wrap ? '0 : pos_inc[fpa_pkg::PIX_W-1:0];
  assign pib_inc = {1'b0, pib_r} + 1'b1;

  // held item
  logic                        item_v_r, is_rd_r, grey_r, grouped_r, oor_r;
  logic [1:0]                  sub_r;
  logic [fpa_pkg::IDX_W-1:0]   idx_r;
  logic [fpa_pkg::PIX_W-1:0]   pos_item_r, gstart_r;
  logic [fpa_pkg::GRP_W-1:0]   j_r;
  logic [fpa_pkg::BYTE_W-1:0]  red_r, green_r, blue_r;
  logic [fpa_pkg::PROD_W-1:0]  p_red_r, p_green_r, p_blue_r;

  logic busy, in_fire, issue, last, credit_ok;
  logic [fpa_pkg::OUT_CNT_W:0] pending;

  assign busy      = mem_st.clr_busy || geo_start_r || rem_busy;
  // results pending in the output buffer plus a read still in the memory stage
  assign pending   = {1'b0, out_level} + (fpa_pkg::OUT_CNT_W + 1)'(mem_st.rd_inflight);
  assign credit_ok = (pending < (fpa_pkg::OUT_CNT_W + 1)'(fpa_pkg::OUT_DEPTH));
  assign issue     = item_v_r && (!is_rd_r || credit_ok);
  assign last      = is_rd_r || grey_r || (sub_r == fpa_pkg::SUB_LAST);
  assign in_tready = !busy && (!item_v_r || (issue && last));
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      sub_r    <= '0;
      pos_r    <= '0;
      pib_r    <= '0;
      base_r   <= '0;
    end else begin
      if (in_fire) begin
        item_v_r <= 1'b1;
        sub_r    <= '0;
      end else if (issue) begin
        if (last) begin
          item_v_r <= 1'b0;
        end else begin
          sub_r <= sub_r + 1'b1;
        end
      end

      if (rem_done) begin
        pib_r  <= rem_val;
        base_r <= eff_pos - rem_val;
      end else if (in_fire && (in_tuser == fpa_pkg::CMD_ACCUM)) begin
        pos_r <= pos_nxt;
        if (wrap) begin
          pib_r  <= '0;
          base_r <= '0;
        end else if (pib_inc == bsize) begin
          pib_r  <= '0;
          base_r <= pos_nxt;
        end else begin
          pib_r <= pib_inc[fpa_pkg::PIX_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      is_rd_r    <= (in_tuser == fpa_pkg::CMD_READ);
      grey_r     <= (mode_r == fpa_pkg::MODE_GREY);
      grouped_r  <= grouped;
      oor_r      <= ({1'b0, in_idx} >= (fpa_pkg::IDX_W + 1)'(fpa_pkg::ACC_DEPTH));
      idx_r      <= in_idx;
      pos_item_r <= eff_pos;
      gstart_r   <= grp_start;
      j_r        <= grp_j;
      red_r      <= in_red;
      green_r    <= in_green;
      blue_r     <= in_blue;
      p_red_r    <= fpa_pkg::PROD_W'(in_red)   * fpa_pkg::PROD_W'(wr_r);
      p_green_r  <= fpa_pkg::PROD_W'(in_green) * fpa_pkg::PROD_W'(wg_r);
      p_blue_r   <= fpa_pkg::PROD_W'(in_blue)  * fpa_pkg::PROD_W'(wb_r);
    end
  end

  // op build
  logic [fpa_pkg::PROD_W+1:0]  grey_sum;
  logic [fpa_pkg::ACC_W-1:0]   grey_val;
  logic [fpa_pkg::PIX_W-1:0]   line_start;
  logic [fpa_pkg::ACC_AW-1:0]  start3, offset;
  logic [fpa_pkg::BYTE_W-1:0]  color;

  assign grey_sum   = (fpa_pkg::PROD_W + 2)'(p_red_r) + (fpa_pkg::PROD_W + 2)'(p_green_r) +
                      (fpa_pkg::PROD_W + 2)'(p_blue_r);
  assign grey_val   = fpa_pkg::ACC_W'(grey_sum >> shift_r);
  assign line_start = grouped_r ? gstart_r : pos_item_r;
  assign start3     = fpa_pkg::ACC_AW'({line_start, 1'b0}) + fpa_pkg::ACC_AW'(line_start);
  // grouped: plane offset 8*sub plus lane j
  assign offset     = grouped_r ? fpa_pkg::ACC_AW'({sub_r, j_r}) : fpa_pkg::ACC_AW'(sub_r);

  always_comb begin
    case (sub_r)
      2'd0:    color = red_r;
      2'd1:    color = green_r;
      default: color = blue_r;
    endcase
  end

  always_comb begin
    op.valid = issue;
    op.oor   = 1'b0;
    if (is_rd_r) begin
      op.kind  = fpa_pkg::OP_READ;
      op.oor   = oor_r;
      op.addr  = fpa_pkg::ACC_AW'(idx_r);
      op.value = '0;
    end else if (grey_r) begin
      op.kind  = fpa_pkg::OP_ADD;
      op.addr  = fpa_pkg::ACC_AW'(pos_item_r);
      op.value = grey_val;
    end else begin
      op.kind  = fpa_pkg::OP_ADD;
      op.addr  = start3 + offset;
      op.value = fpa_pkg::ACC_W'(color);
    end
  end

endmodule

/* hw/rtl/fpa_acc_mem.sv */
// Accumulator memory: clearing pass, read-modify-write with forwarding.
`timescale 1ns / 1ps

module fpa_acc_mem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fpa_pkg::acc_op_t           op,
  output fpa_pkg::mem_status_t       status,
  output logic                       res_valid,
  output logic [fpa_pkg::ACC_W-1:0]  res_data
);

  logic [fpa_pkg::ACC_W-1:0] mem [fpa_pkg::ACC_DEPTH];

  logic                       clr_busy_r;
  logic [fpa_pkg::ACC_AW-1:0] clr_addr_r;
  fpa_pkg::acc_op_t           op1_r;
  logic [fpa_pkg::ACC_W-1:0]  rdata_r;
  logic                       wr_v_r;
  logic [fpa_pkg::ACC_AW-1:0] wr_addr_r;
  logic [fpa_pkg::ACC_W-1:0]  wr_data_r;

  logic [fpa_pkg::ACC_W-1:0]  cur, sum;
  logic                       do_wr;

  // the write of the previous op lands on the same edge as this op's read
  assign cur   = (wr_v_r && (wr_addr_r == op1_r.addr)) ? wr_data_r : rdata_r;
  assign sum   = cur + op1_r.value;
  assign do_wr = op1_r.valid && (op1_r.kind == fpa_pkg::OP_ADD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      op1_r      <= '0;
      wr_v_r     <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == fpa_pkg::ACC_AW'(fpa_pkg::ACC_DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      op1_r  <= op;
      wr_v_r <= do_wr;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= op1_r.addr;
    wr_data_r <= sum;
  end

  always_ff @(posedge clk) begin
    if (op.valid) begin
      rdata_r <= mem[op.addr];
    end
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (do_wr) begin
      mem[op1_r.addr] <= sum;
    end
  end

  assign status.clr_busy    = clr_busy_r;
  assign status.rd_inflight = op1_r.valid && (op1_r.kind == fpa_pkg::OP_READ);
  assign res_valid          = status.rd_inflight;
  assign res_data           = op1_r.oor ? '0 : cur;

endmodule

/* hw/rtl/fpa_out_buf.sv */
// Small result FIFO in front of the output channel.
`timescale 1ns / 1ps

module fpa_out_buf (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [fpa_pkg::ACC_W-1:0]      push_data,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [fpa_pkg::ACC_W-1:0]      out_tdata,
  output logic [fpa_pkg::OUT_CNT_W-1:0]  level
);

  logic [fpa_pkg::ACC_W-1:0]     buf_r [fpa_pkg::OUT_DEPTH];
  logic [fpa_pkg::OUT_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [fpa_pkg::OUT_CNT_W-1:0] cnt_r;
  logic                          pop;

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = buf_r[rd_ptr_r];
  assign pop        = out_tvalid && out_tready;
  assign level      = cnt_r;

  // the sender holds back reads so that a push never meets a full buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == fpa_pkg::OUT_PTR_W'(fpa_pkg::OUT_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == fpa_pkg::OUT_PTR_W'(fpa_pkg::OUT_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + fpa_pkg::OUT_CNT_W'(push) - fpa_pkg::OUT_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/frame_pixel_accumulator.sv */
// Frame pixel accumulator top level.
// Input channel in_*: one transaction is either an accumulate (in_tuser = 0) carrying an
// RGB pixel, or a read (in_tuser = 1) carrying an accumulator entry index. Pixels arrive
// in raster order; the pixel position is counted inside and wraps at pixel_count.
// Output channel out_*: one transaction per read, carrying the 16-bit entry value
// (0 for an index past the end of the memory). Accumulates return nothing.
// Config port cfg_*: register writes; the user must issue them only while the block is idle,
// which the block itself does not enforce.
// Grey accumulates and reads issue one memory op each; interleaved and planar
// accumulates issue one read-modify-write of the single accumulator memory per color entry.
// A read goes through the held item register, memory stage register and result buffer.
// A write to pixel_count or block_pixels recomputes the block position in a
// bit-serial remainder unit; in_tready is low until it is done.
// Reset: the 49152-entry accumulator is cleared one entry per cycle; in_tready stays
// low until the clearing pass ends. Config writes are accepted throughout.
// Stall: a 3-entry result buffer absorbs output backpressure; a read is held off when
// the buffer could overflow, and while it waits in_tready stays low for every command.
`timescale 1ns / 1ps

module frame_pixel_accumulator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [fpa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fpa_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [fpa_pkg::IN_DATA_W-1:0]        in_tdata,  // red, green, blue, read_index
  input  logic                                 in_tuser,  // command
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic signed [fpa_pkg::ACC_W-1:0]     out_tdata  // read_value
);

  fpa_pkg::acc_op_t               op;
  fpa_pkg::mem_status_t           mem_st;
  logic                           res_valid;
  logic [fpa_pkg::ACC_W-1:0]      res_data;
  logic [fpa_pkg::OUT_CNT_W-1:0]  out_level;
  logic [fpa_pkg::ACC_W-1:0]      out_data;

  fpa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .mem_st    (mem_st),
    .out_level (out_level),
    .op        (op)
  );

  fpa_acc_mem u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .status    (mem_st),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  fpa_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_data),
    .level      (out_level)
  );

  assign out_tdata = signed'(out_data);

endmodule

/* hw/rtl/fpa_checker.sv */
// Port-level assertions for the frame pixel accumulator, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fpa_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 cfg_we,
  input logic [fpa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input logic [fpa_pkg::CFG_W-1:0]            cfg_wdata,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic [fpa_pkg::IN_DATA_W-1:0]        in_tdata,
  input logic                                 in_tuser,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic signed [fpa_pkg::ACC_W-1:0]     out_tdata
);

  // reset starts the clearing pass: no input taken right after it
  `FPA_ASSERT_NXT_ALWAYS(a_reset_blocks_input, clk, !rst_n, !in_tready ##1 !in_tready, "input ready during clearing pass")

  // reset empties the result buffer
  `FPA_ASSERT_NXT_ALWAYS(a_reset_flushes_output, clk, !rst_n, !out_tvalid, "result pending after reset")

  // a frame or block size change holds input while the block position is rebuilt
  `FPA_ASSERT_NXT(a_geometry_recompute, clk, rst_n, cfg_we && ((cfg_index == fpa_pkg::REG_PIXEL_COUNT) || (cfg_index == fpa_pkg::REG_BLOCK_PIXELS)), !in_tready, "input ready during geometry recompute")

  // a stalled result stays put
  `FPA_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

endmodule

bind frame_pixel_accumulator fpa_checker u_fpa_checker (.*);

/* verif/frame_pixel_accumulator_test.sv */
// Self-checking testbench for the frame pixel accumulator: directed table plus random frames.
`timescale 1ns / 1ps

module frame_pixel_accumulator_test;

  localparam int STALL_LIMIT  = 200000;  // covers the clear pass after reset
  localparam int IDLE_PAUSE   = 10;
  localparam int END_PAUSE    = 20;
  localparam int RANDOM_ITEMS = 1300;

  localparam logic [fpa_pkg::MODE_W-1:0] MODE_PLANAR       = 2'd2;
  localparam logic [fpa_pkg::MODE_W-1:0] MODE_PLANAR_ALIAS = 2'd3;

  typedef enum logic [1:0] {
    STEP_CFG,
    STEP_PIXEL,
    STEP_READ
  } step_kind_t;

  typedef struct {
    step_kind_t                kind;
    fpa_pkg::reg_idx_t         cfg_reg;
    logic [fpa_pkg::CFG_W-1:0] cfg_val;
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;
    logic [fpa_pkg::IDX_W-1:0] index;
    bit                        typed;
    logic [fpa_pkg::ACC_W-1:0] typed_val;
  } stim_row_t;

  typedef struct {
    logic [fpa_pkg::IDX_W-1:0] index;
    logic [fpa_pkg::ACC_W-1:0] value;
  } read_expect_t;

  logic                              clk;
  logic                              rst_n      = 1'b0;
  logic                              cfg_we     = 1'b0;
  logic [fpa_pkg::CFG_IDX_W-1:0]     cfg_index  = '0;
  logic [fpa_pkg::CFG_W-1:0]         cfg_wdata  = '0;
  logic                              in_tvalid  = 1'b0;
  logic                              in_tready;
  logic [fpa_pkg::IN_DATA_W-1:0]     in_tdata   = '0;  // red, green, blue, read_index
  logic                              in_tuser   = 1'b0;  // command
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic signed [fpa_pkg::ACC_W-1:0]  out_tdata;  // read_value

  frame_pixel_accumulator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Frame memory model and register shadow
  logic [fpa_pkg::ACC_W-1:0]   frame_mem [fpa_pkg::ACC_DEPTH];
  int unsigned                 pixel_pos;
  int unsigned                 recent_addr;
  logic [fpa_pkg::MODE_W-1:0]  mode_reg;
  logic [7:0]                  wt_red, wt_green, wt_blue;
  logic [fpa_pkg::SHIFT_W-1:0] wt_shift;
  logic [fpa_pkg::CFG_W-1:0]   frame_pixels_reg, block_pixels_reg;

  read_expect_t pending_reads [$];
  int           mismatches;
  int           items_sent;
  int           quiet_cycles;
  bit           no_gaps;
  int           ready_hold;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned limit_pixels(input logic [fpa_pkg::CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > fpa_pkg::MAX_PIXELS) return fpa_pkg::MAX_PIXELS;
    return int'(v);
  endfunction

  function automatic void bump_entry(input int unsigned addr, input int unsigned value);
    if (addr < fpa_pkg::ACC_DEPTH) frame_mem[addr] = frame_mem[addr] + value[fpa_pkg::ACC_W-1:0];
  endfunction

  function automatic logic [fpa_pkg::ACC_W-1:0] entry_value(input logic [fpa_pkg::IDX_W-1:0] idx);
    return (int'(idx) < fpa_pkg::ACC_DEPTH) ? frame_mem[idx] : '0;
  endfunction

  function automatic void add_pixel_to_frame(input logic [7:0] r, g, b);
    int unsigned frame, bsize, pos, in_blk, blk_base, span, full, j, base, sum;
    frame = limit_pixels(frame_pixels_reg);
    bsize = limit_pixels(block_pixels_reg);
    pos = pixel_pos;
    if (pos >= frame) pos = 0;
    in_blk = pos % bsize;
    blk_base = pos - in_blk;
    if (mode_reg == fpa_pkg::MODE_GREY) begin
      sum = 32'(r) * 32'(wt_red) + 32'(g) * 32'(wt_green) + 32'(b) * 32'(wt_blue);
      bump_entry(pos, sum >> wt_shift);
      recent_addr = pos + 23;
    end else begin
      span = frame - blk_base;
      if (span > bsize) span = bsize;
      full = span - (span % fpa_pkg::GROUP_PIXELS);
      if (mode_reg != fpa_pkg::MODE_INTERLEAVED && in_blk < full) begin
        // full group of eight: color planes R0..R7, G0..G7, B0..B7
        j = in_blk % fpa_pkg::GROUP_PIXELS;
        base = 3 * (pos - j);
        bump_entry(base + j, 32'(r));
        bump_entry(base + fpa_pkg::GROUP_PIXELS + j, 32'(g));
        bump_entry(base + 2 * fpa_pkg::GROUP_PIXELS + j, 32'(b));
      end else begin
        bump_entry(3 * pos, 32'(r));
        bump_entry(3 * pos + 1, 32'(g));
        bump_entry(3 * pos + 2, 32'(b));
      end
      recent_addr = 3 * pos + 23;
    end
    pos++;
    if (pos >= frame) pos = 0;
    pixel_pos = pos;
  endfunction

  function automatic stim_row_t cfg_row(input fpa_pkg::reg_idx_t r, input int unsigned v);
    stim_row_t s;
    s = '{STEP_CFG, r, fpa_pkg::CFG_W'(v), 8'd0, 8'd0, 8'd0, '0, 1'b0, '0};
    return s;
  endfunction

  function automatic stim_row_t pix_row(input int unsigned r, g, b);
    stim_row_t s;
    s = '{STEP_PIXEL, fpa_pkg::REG_MODE, '0, 8'(r), 8'(g), 8'(b), '0, 1'b0, '0};
    return s;
  endfunction

  function automatic stim_row_t read_row(input int unsigned idx, input bit typed = 1'b0,
                                         input int unsigned val = 0);
    stim_row_t s;
    s = '{STEP_READ, fpa_pkg::REG_MODE, '0, 8'd0, 8'd0, 8'd0, fpa_pkg::IDX_W'(idx), typed,
          fpa_pkg::ACC_W'(val)};
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned pick_pixels(input int unsigned typical_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, typical_max);
    if (r < 75) return $urandom_range(typical_max + 1, 600);
    if (r < 83) return 0;
    if (r < 90) return fpa_pkg::MAX_PIXELS;
    if (r < 95) return $urandom_range(fpa_pkg::MAX_PIXELS + 1, 32767);
    return $urandom_range(1, fpa_pkg::MAX_PIXELS);
  endfunction

  function automatic logic [fpa_pkg::IDX_W-1:0] pick_read_index();
    int r, near;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      near = int'(recent_addr) - int'($urandom_range(0, 47));
      return fpa_pkg::IDX_W'((near < 0) ? 0 : near);
    end
    if (r < 80) begin
      return fpa_pkg::IDX_W'($urandom_range(0, 3 * limit_pixels(frame_pixels_reg) - 1));
    end
    return fpa_pkg::IDX_W'($urandom_range(0, 65535));
  endfunction

  task automatic write_reg(input fpa_pkg::reg_idx_t r, input logic [fpa_pkg::CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(posedge clk);
    case (r)
      fpa_pkg::REG_MODE:         mode_reg = v[fpa_pkg::MODE_W-1:0];
      fpa_pkg::REG_WEIGHT_RED:   wt_red = v[7:0];
      fpa_pkg::REG_WEIGHT_GREEN: wt_green = v[7:0];
      fpa_pkg::REG_WEIGHT_BLUE:  wt_blue = v[7:0];
      fpa_pkg::REG_WEIGHT_SHIFT: wt_shift = v[fpa_pkg::SHIFT_W-1:0];
      fpa_pkg::REG_PIXEL_COUNT:  frame_pixels_reg = v;
      fpa_pkg::REG_BLOCK_PIXELS: block_pixels_reg = v;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Block must be quiet before any register write; accumulates leave no result to wait on.
  task automatic drain_and_idle();
    in_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic send_item(input logic cmd, input logic [7:0] r, g, b,
                           input logic [fpa_pkg::IDX_W-1:0] idx, input bit typed,
                           input logic [fpa_pkg::ACC_W-1:0] typed_val);
    int gap;
    read_expect_t want;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {idx, b, g, r};
    do @(posedge clk); while (in_tready !== 1'b1);
    if (cmd == fpa_pkg::CMD_READ) begin
      want.index = idx;
      want.value = typed ? typed_val : entry_value(idx);
      pending_reads.insert(pending_reads.size(), want);
    end else begin
      add_pixel_to_frame(r, g, b);
    end
    items_sent++;
  endtask

  task automatic setup_random_phase();
    drain_and_idle();
    if ($urandom_range(0, 99) < 80) begin
      write_reg(fpa_pkg::REG_MODE, fpa_pkg::CFG_W'($urandom_range(0, 3)));
    end
    if ($urandom_range(0, 99) < 60) begin
      write_reg(fpa_pkg::REG_WEIGHT_RED, fpa_pkg::CFG_W'(pick_byte()));
    end
    if ($urandom_range(0, 99) < 60) begin
      write_reg(fpa_pkg::REG_WEIGHT_GREEN, fpa_pkg::CFG_W'(pick_byte()));
    end
    if ($urandom_range(0, 99) < 60) begin
      write_reg(fpa_pkg::REG_WEIGHT_BLUE, fpa_pkg::CFG_W'(pick_byte()));
    end
    if ($urandom_range(0, 99) < 60) begin
      write_reg(fpa_pkg::REG_WEIGHT_SHIFT, fpa_pkg::CFG_W'($urandom_range(0, 15)));
    end
    if ($urandom_range(0, 99) < 60) begin
      write_reg(fpa_pkg::REG_PIXEL_COUNT, fpa_pkg::CFG_W'(pick_pixels(48)));
    end
    if ($urandom_range(0, 99) < 60) begin
      write_reg(fpa_pkg::REG_BLOCK_PIXELS, fpa_pkg::CFG_W'(pick_pixels(40)));
    end
    no_gaps = ($urandom_range(0, 99) < 20);
  endtask

  // Result side: random backpressure, mostly short stalls, some long, some long ready runs
  always @(posedge clk) begin
    int r;
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_tready <= 1'b1;
        ready_hold <= $urandom_range(0, 8);
      end else if (r < 85) begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else if (r < 95) begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(10, 40);
      end else begin
        out_tready <= 1'b1;
        ready_hold <= $urandom_range(100, 300);
      end
    end
  end

  always @(posedge clk) begin
    read_expect_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_reads.size() == 0) begin
        if (mismatches < 10) $display("unexpected read result %h", out_tdata);
        mismatches++;
      end else begin
        want = pending_reads.pop_front();
        if (out_tdata !== want.value) begin
          if (mismatches < 10)
            $display("read of entry %0d: expected %h, got %h", want.index, want.value,
                     out_tdata);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t directed [$];
    stim_row_t row;
    bit        prev_cfg;
    logic      cmd;

    foreach (frame_mem[i]) frame_mem[i] = '0;
    pixel_pos        = 0;
    recent_addr      = 0;
    mode_reg         = fpa_pkg::MODE_GREY;
    wt_red           = '0;
    wt_green         = '0;
    wt_blue          = '0;
    wt_shift         = fpa_pkg::SHIFT_W'(8);
    frame_pixels_reg = fpa_pkg::CFG_W'(fpa_pkg::MAX_PIXELS);
    block_pixels_reg = fpa_pkg::CFG_W'(fpa_pkg::MAX_PIXELS);
    mismatches       = 0;
    items_sent       = 0;
    quiet_cycles     = 0;
    ready_hold       = 0;
    no_gaps          = 1'b0;

    directed = '{
      // memory is clear after reset; past the end always reads zero
      read_row(0, 1'b1, 0), read_row(49151, 1'b1, 0),
      read_row(49152, 1'b1, 0), read_row(65535, 1'b1, 0),
      cfg_row(fpa_pkg::REG_MODE, fpa_pkg::MODE_GREY), cfg_row(fpa_pkg::REG_WEIGHT_RED, 255),
      cfg_row(fpa_pkg::REG_WEIGHT_GREEN, 255), cfg_row(fpa_pkg::REG_WEIGHT_BLUE, 255),
      cfg_row(fpa_pkg::REG_WEIGHT_SHIFT, 0), cfg_row(fpa_pkg::REG_PIXEL_COUNT, 4),
      pix_row(255, 255, 255), pix_row(0, 0, 0), pix_row(255, 255, 255),
      read_row(0), read_row(2),
      // frame shrinks under the current position: restart at pixel zero
      cfg_row(fpa_pkg::REG_PIXEL_COUNT, 2), cfg_row(fpa_pkg::REG_WEIGHT_SHIFT, 15),
      pix_row(255, 255, 255), read_row(0),
      cfg_row(fpa_pkg::REG_MODE, fpa_pkg::MODE_INTERLEAVED),
      cfg_row(fpa_pkg::REG_PIXEL_COUNT, 0),
      pix_row(255, 0, 128), pix_row(1, 2, 3),
      read_row(0), read_row(1), read_row(2),
      cfg_row(fpa_pkg::REG_MODE, MODE_PLANAR_ALIAS), cfg_row(fpa_pkg::REG_PIXEL_COUNT, 32767),
      cfg_row(fpa_pkg::REG_BLOCK_PIXELS, 0),
      pix_row(10, 20, 30), read_row(1),
      cfg_row(fpa_pkg::REG_BLOCK_PIXELS, 16), cfg_row(fpa_pkg::REG_MODE, MODE_PLANAR),
      pix_row(7, 8, 9), read_row(9), read_row(17),
      cfg_row(fpa_pkg::REG_BLOCK_PIXELS, 32767),
      pix_row(170, 85, 255), read_row(18), read_row(50000, 1'b1, 0)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    prev_cfg = 1'b1;
    foreach (directed[i]) begin
      row = directed[i];
      if (row.kind == STEP_CFG) begin
        if (!prev_cfg) drain_and_idle();
        write_reg(row.cfg_reg, row.cfg_val);
        prev_cfg = 1'b1;
      end else begin
        cmd = (row.kind == STEP_READ) ? fpa_pkg::CMD_READ : fpa_pkg::CMD_ACCUM;
        send_item(cmd, row.red, row.green, row.blue, row.index, row.typed, row.typed_val);
        prev_cfg = 1'b0;
      end
    end

    while (items_sent < RANDOM_ITEMS) begin
      setup_random_phase();
      repeat ($urandom_range(30, 120)) begin
        cmd = ($urandom_range(0, 99) < 30) ? fpa_pkg::CMD_READ : fpa_pkg::CMD_ACCUM;
        send_item(cmd, pick_byte(), pick_byte(), pick_byte(), pick_read_index(), 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (END_PAUSE) @(posedge clk);

    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_rem_unit.sv
hw/rtl/fpa_front.sv
hw/rtl/fpa_acc_mem.sv
hw/rtl/fpa_out_buf.sv
hw/rtl/frame_pixel_accumulator.sv
hw/rtl/fpa_checker.sv
verif/frame_pixel_accumulator_test.sv
